// File: rtl/utf8_stream_decoder_assert.svh
// assertion macros for the utf8 stream decoder checks
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// condition holds in the same cycle
`define USD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/usd_pkg.sv
package usd_pkg;

    localparam logic [7:0] ASCII_MASK  = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] LEAD2_BITS  = 8'h1F;
    localparam logic [7:0] LEAD3_BITS  = 8'h0F;
    localparam logic [7:0] LEAD4_BITS  = 8'h07;
    localparam logic [7:0] CONT_BITS   = 8'h3F;

    localparam int CODE_W  = 21;
    localparam int FIELD_W = 16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } usd_byte_t;

    typedef struct packed {
        logic               code_valid;
        logic [CODE_W-1:0]  code_point;
        logic [FIELD_W-1:0] char_start;
        logic               string_done;
        logic [FIELD_W-1:0] char_total;
        logic               malformed;
        logic [FIELD_W-1:0] bad_position;
    } usd_result_t;

endpackage

// File: rtl/usd_stream_if.sv
interface usd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface usd_char_if;
    logic        valid;
    logic        ready;
    logic        code_valid;
    logic [20:0] code_point;
    logic [15:0] char_start;
    logic        string_done;
    logic [15:0] char_total;
    logic        malformed;
    logic [15:0] bad_position;

    modport source (
        output valid, output code_valid, output code_point, output char_start,
        output string_done, output char_total, output malformed, output bad_position,
        input ready
    );
    modport sink (
        input valid, input code_valid, input code_point, input char_start,
        input string_done, input char_total, input malformed, input bad_position,
        output ready
    );
endinterface

// File: rtl/usd_input_stage.sv
module usd_input_stage
    import usd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    input  usd_byte_t item,
    output logic      item_ready,
    output logic      stage_valid,
    output usd_byte_t stage_item,
    input  logic      take
);

    logic      valid_reg;
    logic      valid_next;
    usd_byte_t item_reg;

    assign item_ready  = !valid_reg || take;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_ready)
        begin
            valid_next = item_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

endmodule

// File: rtl/usd_decoder.sv
module usd_decoder
    import usd_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  usd_byte_t   item,
    output usd_result_t result
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    logic [1:0]               pend_reg,    pend_next;
    logic [CODE_W-1:0]        partial_reg, partial_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic [POSITION_BITS-1:0] seq_reg,     seq_next;
    logic [POSITION_BITS-1:0] count_reg,   count_next;
    logic                     err_reg,     err_next;
    logic [POSITION_BITS-1:0] err_pos_reg, err_pos_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] count_inc;
    logic [POSITION_BITS-1:0] start_pos;
    logic [CODE_W-1:0]        code;
    logic                     valid;
    logic [7:0]               b;
    logic [CODE_W-1:0]        shifted;

    logic [POSITION_BITS+FIELD_W-1:0] start_wide;
    logic [POSITION_BITS+FIELD_W-1:0] count_wide;
    logic [POSITION_BITS+FIELD_W-1:0] err_pos_wide;

    assign b         = item.data_byte;
    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POS_ONE;
    assign count_inc = (count_reg == POS_MAX) ? count_reg : count_reg + POS_ONE;
    assign shifted   = {partial_reg[CODE_W-7:0], b[5:0]};

    // decode one byte against the current sequence state
    always_comb
    begin
        pend_next    = pend_reg;
        partial_next = partial_reg;
        seq_next     = seq_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        err_pos_next = err_pos_reg;
        pos_next     = pos_inc;
        valid        = 1'b0;
        code         = '0;
        start_pos    = '0;
        if (!err_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                if ((b & ASCII_MASK) == 8'h00)
                begin
                    valid      = 1'b1;
                    code       = {{(CODE_W-8){1'b0}}, b};
                    start_pos  = pos_inc;
                    count_next = count_inc;
                end
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    partial_next = {{(CODE_W-8){1'b0}}, b & LEAD2_BITS};
                    pend_next    = 2'd1;
                    seq_next     = pos_inc;
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    partial_next = {{(CODE_W-8){1'b0}}, b & LEAD3_BITS};
                    pend_next    = 2'd2;
                    seq_next     = pos_inc;
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    partial_next = {{(CODE_W-8){1'b0}}, b & LEAD4_BITS};
                    pend_next    = 2'd3;
                    seq_next     = pos_inc;
                end
                else
                begin
                    err_next     = 1'b1;
                    err_pos_next = pos_inc;
                    pend_next    = 2'd0;
                    partial_next = '0;
                end
            end
            else if ((b & CONT_MASK) == CONT_CODE)
            begin
                pend_next    = pend_reg - 2'd1;
                partial_next = shifted;
                if (pend_reg == 2'd1)
                begin
                    valid        = 1'b1;
                    code         = shifted;
                    start_pos    = seq_reg;
                    count_next   = count_inc;
                    partial_next = '0;
                end
            end
            else
            begin
                err_next     = 1'b1;
                err_pos_next = seq_reg;
                pend_next    = 2'd0;
                partial_next = '0;
            end
            // string ends inside a sequence
            if (item.end_of_string && !err_next && (pend_next != 2'd0))
            begin
                err_next     = 1'b1;
                err_pos_next = seq_next;
                pend_next    = 2'd0;
                partial_next = '0;
            end
        end
    end

    assign start_wide   = {{FIELD_W{1'b0}}, start_pos};
    assign count_wide   = {{FIELD_W{1'b0}}, count_next};
    assign err_pos_wide = {{FIELD_W{1'b0}}, err_pos_next};

    always_comb
    begin
        result.code_valid   = valid;
        result.code_point   = code;
        result.char_start   = start_wide[FIELD_W-1:0];
        result.string_done  = item.end_of_string;
        result.char_total   = count_wide[FIELD_W-1:0];
        result.malformed    = err_next;
        result.bad_position = err_pos_wide[FIELD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            partial_reg <= '0;
            pos_reg     <= '0;
            seq_reg     <= '0;
            count_reg   <= '0;
            err_reg     <= 1'b0;
            err_pos_reg <= '0;
        end
        else if (step)
        begin
            if (item.end_of_string)
            begin
                pend_reg    <= '0;
                partial_reg <= '0;
                pos_reg     <= '0;
                seq_reg     <= '0;
                count_reg   <= '0;
                err_reg     <= 1'b0;
                err_pos_reg <= '0;
            end
            else
            begin
                pend_reg    <= pend_next;
                partial_reg <= partial_next;
                pos_reg     <= pos_next;
                seq_reg     <= seq_next;
                count_reg   <= count_next;
                err_reg     <= err_next;
                err_pos_reg <= err_pos_next;
            end
        end
    end

endmodule

// File: rtl/usd_result_stage.sv
module usd_result_stage
    import usd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  usd_result_t result,
    output logic        space,
    output logic        out_valid,
    output usd_result_t out_result,
    input  logic        out_ready
);

    logic        valid_reg;
    logic        valid_next;
    usd_result_t result_reg;

    assign space      = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_result = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (space)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

endmodule

// File: rtl/utf8_stream_decoder.sv
// channel       role    payload
// byte_stream   sink    data_byte, end_of_string
// char_stream   source  code_valid, code_point, char_start, string_done,
//                       char_total, malformed, bad_position
//
// one byte per cycle sustained while char_stream is ready; input register, then result register
// the decode step between the two registers updates the sequence state
// reset clears all sequence state and both stage valids
// a stall on char_stream fills the two registers, then byte_stream.ready drops
module utf8_stream_decoder
    import usd_pkg::*;
#(
    parameter int POSITION_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    usd_byte_if.sink   byte_stream,
    usd_char_if.source char_stream
);

    usd_byte_t   in_item;
    usd_byte_t   stage_item;
    usd_result_t step_result;
    usd_result_t out_result;
    logic        stage_valid;
    logic        space;
    logic        take;

    assign in_item.data_byte     = byte_stream.data_byte;
    assign in_item.end_of_string = byte_stream.end_of_string;
    assign take                  = stage_valid && space;

    usd_input_stage u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (byte_stream.valid),
        .item        (in_item),
        .item_ready  (byte_stream.ready),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .take        (take)
    );

    usd_decoder #(
        .POSITION_BITS (POSITION_BITS)
    ) u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (stage_item),
        .result (step_result)
    );

    usd_result_stage u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take),
        .result     (step_result),
        .space      (space),
        .out_valid  (char_stream.valid),
        .out_result (out_result),
        .out_ready  (char_stream.ready)
    );

    assign char_stream.code_valid   = out_result.code_valid;
    assign char_stream.code_point   = out_result.code_point;
    assign char_stream.char_start   = out_result.char_start;
    assign char_stream.string_done  = out_result.string_done;
    assign char_stream.char_total   = out_result.char_total;
    assign char_stream.malformed    = out_result.malformed;
    assign char_stream.bad_position = out_result.bad_position;

endmodule

// File: rtl/usd_checker.sv
`include "utf8_stream_decoder_assert.svh"

module usd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        code_valid,
    input logic [20:0] code_point,
    input logic [15:0] char_start,
    input logic [15:0] char_total,
    input logic        malformed,
    input logic [15:0] bad_position
);

    `USD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(code_point), "stalled item changed")
    `USD_ASSERT_NOW(a_idle_fields, out_valid && !code_valid, code_point == 21'd0 && char_start == 16'd0, "fields set without a code point")
    `USD_ASSERT_NOW(a_count_live, out_valid && code_valid, char_total != 16'd0 && char_start != 16'd0, "completed char not counted")
    `USD_ASSERT_NOW(a_no_code_after_error, out_valid && code_valid, !malformed, "code point after an error")
    `USD_ASSERT_NOW(a_clean_position, out_valid && !malformed, bad_position == 16'd0, "error position without an error")

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (char_stream.valid),
    .out_ready    (char_stream.ready),
    .code_valid   (char_stream.code_valid),
    .code_point   (char_stream.code_point),
    .char_start   (char_stream.char_start),
    .char_total   (char_stream.char_total),
    .malformed    (char_stream.malformed),
    .bad_position (char_stream.bad_position)
);

// File: verif/tb_utf8_stream_decoder.sv
`timescale 1ns / 100ps

module tb_utf8_stream_decoder;
    import usd_pkg::*;

    localparam logic [15:0] POS_MAX = 16'hFFFF;
    localparam int RANDOM_BYTES = 450;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        usd_byte_t   in;
        logic        typed;
        usd_result_t res;
    } dir_row_t;

    // typed rows carry their result, the others go through the decoder model
    localparam dir_row_t DIR_TABLE [26] = '{
        '{'{8'h00, 1'b1}, 1'b1, '{1'b1, 21'h0, 16'd1, 1'b1, 16'd1, 1'b0, 16'd0}},
        '{'{8'h7F, 1'b0}, 1'b1, '{1'b1, 21'h7F, 16'd1, 1'b0, 16'd1, 1'b0, 16'd0}},
        '{'{8'hC3, 1'b0}, 1'b1, '{1'b0, 21'h0, 16'd0, 1'b0, 16'd1, 1'b0, 16'd0}},
        '{'{8'hA9, 1'b0}, 1'b0, '0},
        '{'{8'hE2, 1'b0}, 1'b0, '0},
        '{'{8'h82, 1'b0}, 1'b0, '0},
        '{'{8'hAC, 1'b0}, 1'b0, '0},
        '{'{8'hF7, 1'b0}, 1'b0, '0},
        '{'{8'hBF, 1'b0}, 1'b0, '0},
        '{'{8'hBF, 1'b0}, 1'b0, '0},
        '{'{8'hBF, 1'b1}, 1'b1, '{1'b1, 21'h1FFFFF, 16'd7, 1'b1, 16'd4, 1'b0, 16'd0}},
        '{'{8'h80, 1'b0}, 1'b1, '{1'b0, 21'h0, 16'd0, 1'b0, 16'd0, 1'b1, 16'd1}},
        '{'{8'h41, 1'b1}, 1'b1, '{1'b0, 21'h0, 16'd0, 1'b1, 16'd0, 1'b1, 16'd1}},
        '{'{8'h41, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b1}, 1'b1, '{1'b0, 21'h0, 16'd0, 1'b1, 16'd1, 1'b1, 16'd2}},
        '{'{8'hE0, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{'{8'h41, 1'b1}, 1'b1, '{1'b0, 21'h0, 16'd0, 1'b1, 16'd0, 1'b1, 16'd1}},
        '{'{8'h61, 1'b0}, 1'b0, '0},
        '{'{8'hF0, 1'b0}, 1'b0, '0},
        '{'{8'h90, 1'b1}, 1'b1, '{1'b0, 21'h0, 16'd0, 1'b1, 16'd1, 1'b1, 16'd2}},
        '{'{8'hC0, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b1}, 1'b0, '0},
        '{'{8'hED, 1'b0}, 1'b0, '0},
        '{'{8'hA0, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b1}, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    usd_byte_if byte_if ();
    usd_char_if char_if ();

    utf8_stream_decoder #(
        .POSITION_BITS (16)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_if),
        .char_stream (char_if)
    );

    // decoder model state
    logic [1:0]  need_cont;
    logic [20:0] code_acc;
    logic [15:0] byte_pos;
    logic [15:0] lead_pos;
    logic [15:0] chars_done;
    logic        fault_seen;
    logic [15:0] fault_pos;

    usd_result_t decoded_q [$];
    logic [7:0]  string_bytes [$];

    int fault_count = 0;
    int shown = 0;
    int hold_req = 0;
    int bytes_sent = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic void append_byte(input logic [7:0] b);
        string_bytes.insert(string_bytes.size(), b);
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == POS_MAX) ? v : v + 16'd1;
    endfunction

    function automatic void clear_decoder();
        need_cont = 2'd0;
        code_acc = '0;
        byte_pos = '0;
        lead_pos = '0;
        chars_done = '0;
        fault_seen = 1'b0;
        fault_pos = '0;
    endfunction

    function automatic void latch_fault(input logic [15:0] where);
        fault_seen = 1'b1;
        fault_pos = where;
        need_cont = 2'd0;
        code_acc = '0;
    endfunction

    function automatic usd_result_t decode_byte(input logic [7:0] b, input logic eos);
        usd_result_t r;
        r = '0;
        byte_pos = sat_inc(byte_pos);
        if (!fault_seen)
        begin
            if (need_cont == 2'd0)
            begin
                if ((b & ASCII_MASK) == 8'h00)
                begin
                    r.code_valid = 1'b1;
                    r.code_point = {13'd0, b};
                    r.char_start = byte_pos;
                    chars_done = sat_inc(chars_done);
                end
                else if ((b & LEAD2_MASK) == LEAD2_CODE)
                begin
                    code_acc = {13'd0, b & LEAD2_BITS};
                    need_cont = 2'd1;
                    lead_pos = byte_pos;
                end
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                begin
                    code_acc = {13'd0, b & LEAD3_BITS};
                    need_cont = 2'd2;
                    lead_pos = byte_pos;
                end
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                begin
                    code_acc = {13'd0, b & LEAD4_BITS};
                    need_cont = 2'd3;
                    lead_pos = byte_pos;
                end
                else
                begin
                    latch_fault(byte_pos);
                end
            end
            else if ((b & CONT_MASK) == CONT_CODE)
            begin
                code_acc = {code_acc[14:0], b[5:0]};
                need_cont = need_cont - 2'd1;
                if (need_cont == 2'd0)
                begin
                    r.code_valid = 1'b1;
                    r.code_point = code_acc;
                    r.char_start = lead_pos;
                    chars_done = sat_inc(chars_done);
                    code_acc = '0;
                end
            end
            else
            begin
                latch_fault(lead_pos);
            end
            // string ends inside a sequence
            if (eos && !fault_seen && need_cont != 2'd0)
                latch_fault(lead_pos);
        end
        r.string_done = eos;
        r.char_total = chars_done;
        r.malformed = fault_seen;
        r.bad_position = fault_pos;
        if (eos)
            clear_decoder();
        return r;
    endfunction

    function automatic int field_errors(input usd_result_t got, input usd_result_t want);
        int n;
        n = 0;
        n += int'(got.code_valid !== want.code_valid);
        n += int'(got.code_point !== want.code_point);
        n += int'(got.char_start !== want.char_start);
        n += int'(got.string_done !== want.string_done);
        n += int'(got.char_total !== want.char_total);
        n += int'(got.malformed !== want.malformed);
        n += int'(got.bad_position !== want.bad_position);
        return n;
    endfunction

    function automatic logic [7:0] rand_cont();
        return CONT_CODE | (8'($urandom) & CONT_BITS);
    endfunction

    function automatic logic [7:0] rand_lead(input int len);
        if (len == 1)
            return LEAD2_CODE | (8'($urandom) & LEAD2_BITS);
        else if (len == 2)
            return LEAD3_CODE | (8'($urandom) & LEAD3_BITS);
        return LEAD4_CODE | (8'($urandom) & LEAD4_BITS);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                             input usd_result_t typed_res);
        int gap;
        usd_result_t r;
        gap = $urandom_range(0, 3);
        repeat (gap)
        begin
            @(negedge clk);
            byte_if.valid <= 1'b0;
        end
        @(negedge clk);
        byte_if.valid <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.end_of_string <= eos;
        do
            @(posedge clk);
        while (byte_if.ready !== 1'b1);
        r = decode_byte(b, eos);
        decoded_q.insert(decoded_q.size(), typed ? typed_res : r);
        bytes_sent++;
    endtask

    task automatic send_string();
        for (int i = 0; i < string_bytes.size(); i++)
            send_byte(string_bytes[i], i == string_bytes.size() - 1, 1'b0, '0);
    endtask

    task automatic drain();
        @(negedge clk);
        byte_if.valid <= 1'b0;
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic add_char(input int len);
        if (len == 0)
        begin
            append_byte(8'($urandom_range(0, 127)));
        end
        else
        begin
            append_byte(rand_lead(len));
            repeat (len) append_byte(rand_cont());
        end
    endtask

    task automatic compose_string();
        int mode;
        int idx;
        int len;
        string_bytes.delete();
        mode = $urandom_range(0, 9);
        if (mode == 0)
        begin
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 8)) add_char($urandom_range(0, 3));
            if (mode <= 2)
            begin
                idx = $urandom_range(0, string_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        if ($urandom_range(0, 1) == 1)
                            string_bytes.insert(idx, rand_cont());
                        else
                            string_bytes.insert(idx, LEAD4_MASK | (8'($urandom) & LEAD4_BITS));
                    end
                    1:
                    begin
                        string_bytes[idx] = 8'($urandom);
                    end
                    default:
                    begin
                        // sequence cut short by the end of the string
                        len = $urandom_range(2, 3);
                        append_byte(rand_lead(len));
                        repeat ($urandom_range(0, len - 1)) append_byte(rand_cont());
                    end
                endcase
            end
        end
    endtask

    initial
    begin : char_sink
        usd_result_t got;
        usd_result_t want;
        int stall;
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req != 0)
            begin
                n = hold_req;
                hold_req = 0;
                repeat (n)
                begin
                    @(negedge clk);
                    char_if.ready <= 1'b0;
                end
            end
            stall = $urandom_range(0, 3);
            repeat (stall)
            begin
                @(negedge clk);
                char_if.ready <= 1'b0;
            end
            @(negedge clk);
            char_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (char_if.valid !== 1'b1);
            got.code_valid = char_if.code_valid;
            got.code_point = char_if.code_point;
            got.char_start = char_if.char_start;
            got.string_done = char_if.string_done;
            got.char_total = char_if.char_total;
            got.malformed = char_if.malformed;
            got.bad_position = char_if.bad_position;
            if (decoded_q.size() == 0)
            begin
                fault_count++;
                if (shown < MAX_SHOWN)
                begin
                    shown++;
                    $display("unexpected item: %h", got);
                end
            end
            else
            begin
                want = decoded_q.pop_front();
                if (field_errors(got, want) != 0)
                begin
                    fault_count++;
                    if (shown < MAX_SHOWN)
                    begin
                        shown++;
                        $display("mismatch exp/act: valid %0b/%0b code %h/%h start %0d/%0d",
                                 want.code_valid, got.code_valid, want.code_point,
                                 got.code_point, want.char_start, got.char_start);
                        $display("  done %0b/%0b total %0d/%0d malformed %0b/%0b bad %0d/%0d",
                                 want.string_done, got.string_done, want.char_total,
                                 got.char_total, want.malformed, got.malformed,
                                 want.bad_position, got.bad_position);
                    end
                end
            end
        end
    end

    initial
    begin : byte_source
        bit paused;
        paused = 1'b0;
        rst_n = 1'b0;
        byte_if.valid = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.end_of_string = 1'b0;
        char_if.ready = 1'b0;
        clear_decoder();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 26; i++)
            send_byte(DIR_TABLE[i].in.data_byte, DIR_TABLE[i].in.end_of_string,
                      DIR_TABLE[i].typed, DIR_TABLE[i].res);
        drain();

        // long output stall while bytes keep coming
        hold_req = 80;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            compose_string();
            send_string();
            if (!paused && bytes_sent >= RANDOM_BYTES / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end
        drain();

        fault_count += decoded_q.size();
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
